// ===== rtl/core/video_chip_register_port_top_macros.svh =====
// Assertion macros for the video chip register port.
// Included by the top level; no other dependencies.
`ifndef VIDEO_CHIP_REGISTER_PORT_TOP_MACROS_SVH
`define VIDEO_CHIP_REGISTER_PORT_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define VCRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define VCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VCRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define VCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/vcrp_pkg.sv =====
// Shared types, codes and constants of the video chip register port.
// No dependencies; imported by the top, front and back modules of the block.
`timescale 1ns / 1ps

package vcrp_pkg;

    // Memory sizes
    localparam int PATTERN_BYTES    = 8192;
    localparam int SPRITE_BYTES     = 256;
    localparam int PALETTE_BYTES    = 32;
    localparam int NT_BYTES_DEFAULT = 4096;
    localparam int QUEUE_DEPTH      = 2;

    // Video address space
    localparam int VADDR_W  = 14;
    localparam int NT_RAW_W = 12;
    localparam logic [VADDR_W-1:0] PALETTE_BASE = 14'h3F00;
    localparam int ADDR_STEP_WIDE = 32;

    // Register bits
    localparam int          CTRL_STEP32_BIT = 2;
    localparam logic [7:0]  STATUS_VBLANK   = 8'h80;

    // Function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_EVENT = 2'd2;

    // Register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_SPR_ADDR = 3'd3;
    localparam logic [2:0] REG_SPR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Nametable mirroring modes
    localparam logic [1:0] MIRROR_NONE       = 2'd0;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIRROR_FOUR       = 2'd3;

    // Operation classes handed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_RD_STATUS,
        OP_RD_DATA,
        OP_RD_BUFFER,
        OP_WR_CTRL,
        OP_WR_MASK,
        OP_WR_SPR_ADDR,
        OP_WR_SPR_DATA,
        OP_WR_SCROLL,
        OP_WR_ADDR,
        OP_WR_DATA,
        OP_EVENT
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    // Map a 1 KiB nametable window to its physical page
    function automatic logic [1:0] page_of(input logic [1:0] mode, input logic [1:0] win);
        logic [1:0] page;
        unique case (mode)
            MIRROR_HORIZONTAL: page = {1'b0, win[1]};
            MIRROR_VERTICAL:   page = {1'b0, win[0]};
            MIRROR_NONE,
            MIRROR_FOUR:       page = win;
            default:           page = win;
        endcase
        return page;
    endfunction

endpackage

// ===== rtl/core/video_chip_register_port_top.sv =====
// Top level of the video chip register port: front, operation queue, back, result queue.
// Depends on vcrp_pkg, vcrp_front, vcrp_fifo, vcrp_back and the assertion macro header.
`timescale 1ns / 1ps
`include "video_chip_register_port_top_macros.svh"

// CPU-side register port of a tile video chip, seen as a queue on both sides.
// One bus access is taken per cycle while full is low, and one result byte comes back per
// access, in order; a result passes the input stage, then the operation queue, then is
// executed into the result queue. The back end executes one operation per cycle while
// the result queue has room and no sweep runs, against memories with registered reads;
// a data read refills the read buffer from that memory the following cycle, in time for
// a read right behind it. After reset the pattern and nametable memories are swept to
// zero, one entry per cycle; full stays high until the sweep ends. mirroring_mode is written with
// mirroring_we and may change only while no access is in flight.
module video_chip_register_port_top import vcrp_pkg::*; #(
    parameter int NAMETABLE_BYTES = NT_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mirroring_we,
    input  logic [1:0] mirroring_mode,
    input  logic       push,
    output logic       full,
    input  logic [1:0] func,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] read_data
);

    logic [1:0] mirroring_mode_reg;
    logic       clearing;
    logic       q_push;
    logic       q_full;
    op_t        q_wr_op;
    op_t        q_rd_op;
    logic       q_empty;
    logic       op_pop;
    logic       res_push;
    logic       res_full;
    logic [7:0] res_data;

    // Hold the mirroring register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirroring_mode_reg <= MIRROR_NONE;
        end
        else if (mirroring_we)
        begin
            mirroring_mode_reg <= mirroring_mode;
        end
    end

    vcrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .reg_index  (reg_index),
        .write_data (write_data),
        .clearing   (clearing),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (q_wr_op)
    );

    vcrp_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wr_op),
        .full  (q_full),
        .pop   (op_pop),
        .rdata (q_rd_op),
        .empty (q_empty)
    );

    vcrp_back #(
        .NAMETABLE_BYTES (NAMETABLE_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mirroring_mode (mirroring_mode_reg),
        .op_valid       (!q_empty),
        .op             (q_rd_op),
        .op_pop         (op_pop),
        .res_full       (res_full),
        .res_push       (res_push),
        .res_data       (res_data),
        .clearing       (clearing)
    );

    vcrp_fifo #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (read_data),
        .empty (empty)
    );

    // No access enters or waits while the memories are being cleared
    `VCRP_ASSERT_NOW(a_clear_blocks, clk, rst_n, clearing, full && q_empty && !res_push, "access seen during clearing pass")
    // The back end never executes into a full result queue
    `VCRP_ASSERT_NOW(a_res_no_overflow, clk, rst_n, res_push, !res_full, "result pushed into full queue")
    // The front end never pushes into a full operation queue
    `VCRP_ASSERT_NOW(a_op_no_overflow, clk, rst_n, q_push, !q_full, "operation pushed into full queue")
    // Once the sweep is over it does not start again without reset
    `VCRP_ASSERT_NEXT(a_clear_once, clk, rst_n, !clearing, !clearing, "clearing pass restarted")

endmodule

// ===== rtl/core/vcrp_fifo.sv =====
// Small synchronous queue with full/empty flags.
// Used between front and back and at the result side; no package dependencies.
`timescale 1ns / 1ps

module vcrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/vcrp_front.sv =====
// Front end: accepts bus accesses and classifies them into operations.
// Depends on vcrp_pkg; feeds the operation queue.
`timescale 1ns / 1ps

module vcrp_front import vcrp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] func,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_data,
    input  logic       clearing,
    input  logic       q_full,
    output logic       q_push,
    output op_t        q_op
);

    logic stage_valid_reg, stage_valid_next;
    op_t  stage_op_reg;
    op_t  op_class;
    logic accept;

    // Classify one access by function and register number
    always_comb
    begin
        op_class.data = write_data;
        unique case (func)
            FUNC_READ:
            begin
                priority case (reg_index)
                    REG_STATUS: op_class.kind = OP_RD_STATUS;
                    REG_DATA:   op_class.kind = OP_RD_DATA;
                    default:    op_class.kind = OP_RD_BUFFER;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (reg_index)
                    REG_CTRL:     op_class.kind = OP_WR_CTRL;
                    REG_MASK:     op_class.kind = OP_WR_MASK;
                    REG_STATUS:   op_class.kind = OP_NOP;
                    REG_SPR_ADDR: op_class.kind = OP_WR_SPR_ADDR;
                    REG_SPR_DATA: op_class.kind = OP_WR_SPR_DATA;
                    REG_SCROLL:   op_class.kind = OP_WR_SCROLL;
                    REG_ADDR:     op_class.kind = OP_WR_ADDR;
                    REG_DATA:     op_class.kind = OP_WR_DATA;
                    default:      op_class.kind = OP_NOP;
                endcase
            end
            FUNC_EVENT: op_class.kind = OP_EVENT;
            default:    op_class.kind = OP_NOP;
        endcase
    end

    // Stall while the memories are cleared or the stage cannot drain
    assign full   = clearing || (stage_valid_reg && q_full);
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_op   = stage_op_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Capture the classified operation on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_op_reg <= op_class;
        end
    end

endmodule

// ===== rtl/core/vcrp_back.sv =====
// Back end: register file, video memories and the post-reset clearing pass.
// Depends on vcrp_pkg; drains the operation queue into the result queue.
`timescale 1ns / 1ps

module vcrp_back import vcrp_pkg::*; #(
    parameter int NAMETABLE_BYTES = NT_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] mirroring_mode,
    input  logic       op_valid,
    input  op_t        op,
    output logic       op_pop,
    input  logic       res_full,
    output logic       res_push,
    output logic [7:0] res_data,
    output logic       clearing
);

    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);

    // Architectural registers
    logic [7:0]         control_reg;
    logic [7:0]         mask_reg;
    logic [SPR_AW-1:0]  sprite_addr_reg;
    logic [7:0]         scroll_reg [2];
    logic               write_toggle_reg;
    logic [7:0]         addr_high_hold_reg;
    logic [VADDR_W-1:0] video_addr_reg;
    logic               first_read_pending_reg;
    logic [7:0]         status_flags_reg;
    logic [7:0]         palette_reg [PALETTE_BYTES];

    // Memories and their read data
    logic [7:0]         sprite_mem [SPRITE_BYTES];
    logic [7:0]         pattern_mem [PATTERN_BYTES];
    logic [7:0]         nametable_mem [NAMETABLE_BYTES];
    logic [7:0]         pat_q_reg;
    logic [7:0]         nt_q_reg;
    logic               buf_from_mem_reg;
    logic               sel_pat_reg;

    // Clearing pass
    logic               clear_active_reg;
    logic [PAT_AW-1:0]  clear_idx_reg;

    logic               fire;
    logic               is_rd;
    logic               is_wr;
    logic [VADDR_W-1:0] step;
    logic [VADDR_W-1:0] addr_stepped;
    logic [VADDR_W-1:0] rd_addr;
    logic [VADDR_W-1:0] mem_addr;
    logic               mem_in_pat;
    logic               in_palette;
    logic [NT_RAW_W-1:0] nt_raw;
    logic [NT_RAW_W:0]  nt_wide;
    logic [NT_RAW_W:0]  nt_red;
    logic [NT_AW-1:0]   nt_idx;
    logic [7:0]         buf_q;
    logic               pat_we;
    logic [PAT_AW-1:0]  pat_waddr;
    logic [7:0]         pat_wdata;
    logic               pat_rd;
    logic               nt_we;
    logic [NT_AW-1:0]   nt_waddr;
    logic [7:0]         nt_wdata;
    logic               nt_rd;

    assign clearing = clear_active_reg;
    assign fire     = op_valid && !res_full && !clear_active_reg;
    assign op_pop   = fire;
    assign res_push = fire;
    assign is_rd    = (op.kind == OP_RD_DATA);
    assign is_wr    = (op.kind == OP_WR_DATA);

    // Address stepping and memory address selection
    always_comb
    begin
        step         = control_reg[CTRL_STEP32_BIT] ? VADDR_W'(ADDR_STEP_WIDE) : VADDR_W'(1);
        addr_stepped = video_addr_reg + step;
        rd_addr      = first_read_pending_reg ? video_addr_reg : addr_stepped;
        mem_addr     = is_rd ? rd_addr : video_addr_reg;
        mem_in_pat   = !mem_addr[VADDR_W-1];
        in_palette   = (mem_addr >= PALETTE_BASE);
    end

    // Map into the nametable and wrap once at its size
    always_comb
    begin
        nt_raw  = {page_of(mirroring_mode, mem_addr[11:10]), mem_addr[9:0]};
        nt_wide = {1'b0, nt_raw};
        if (nt_wide >= (NT_RAW_W + 1)'(NAMETABLE_BYTES))
        begin
            nt_red = nt_wide - (NT_RAW_W + 1)'(NAMETABLE_BYTES);
        end
        else
        begin
            nt_red = nt_wide;
        end
        nt_idx = nt_red[NT_AW-1:0];
    end

    // Read buffer: zero until the first refill, then the last memory read
    always_comb
    begin
        if (!buf_from_mem_reg)
        begin
            buf_q = 8'h00;
        end
        else if (sel_pat_reg)
        begin
            buf_q = pat_q_reg;
        end
        else
        begin
            buf_q = nt_q_reg;
        end
    end

    // Result of each operation
    always_comb
    begin
        unique case (op.kind)
            OP_RD_STATUS: res_data = status_flags_reg;
            OP_RD_DATA,
            OP_RD_BUFFER: res_data = buf_q;
            default:      res_data = 8'h00;
        endcase
    end

    // Memory port controls; clearing owns the write ports
    always_comb
    begin
        pat_rd    = fire && is_rd && mem_in_pat;
        nt_rd     = fire && is_rd && !mem_in_pat;
        pat_we    = clear_active_reg || (fire && is_wr && mem_in_pat);
        pat_waddr = clear_active_reg ? clear_idx_reg : mem_addr[PAT_AW-1:0];
        pat_wdata = clear_active_reg ? 8'h00 : op.data;
        nt_we     = (clear_active_reg && (clear_idx_reg < PAT_AW'(NAMETABLE_BYTES)))
                    || (fire && is_wr && !mem_in_pat && !in_palette);
        nt_waddr  = clear_active_reg ? clear_idx_reg[NT_AW-1:0] : nt_idx;
        nt_wdata  = clear_active_reg ? 8'h00 : op.data;
    end

    // Sweep both memories once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_idx_reg    <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
            if (clear_idx_reg == PAT_AW'(PATTERN_BYTES - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // Execute one operation against the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg            <= '0;
            mask_reg               <= '0;
            sprite_addr_reg        <= '0;
            scroll_reg[0]          <= '0;
            scroll_reg[1]          <= '0;
            write_toggle_reg       <= 1'b0;
            addr_high_hold_reg     <= '0;
            video_addr_reg         <= '0;
            first_read_pending_reg <= 1'b0;
            status_flags_reg       <= '0;
            buf_from_mem_reg       <= 1'b0;
            sel_pat_reg            <= 1'b0;
            for (int i = 0; i < PALETTE_BYTES; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            unique case (op.kind)
                OP_RD_STATUS:
                begin
                    status_flags_reg <= status_flags_reg & ~STATUS_VBLANK;
                    write_toggle_reg <= 1'b0;
                end
                OP_RD_DATA:
                begin
                    if (first_read_pending_reg)
                    begin
                        first_read_pending_reg <= 1'b0;
                    end
                    else
                    begin
                        video_addr_reg <= addr_stepped;
                    end
                    buf_from_mem_reg <= 1'b1;
                    sel_pat_reg      <= mem_in_pat;
                end
                OP_WR_CTRL:     control_reg <= op.data;
                OP_WR_MASK:     mask_reg <= op.data;
                OP_WR_SPR_ADDR: sprite_addr_reg <= op.data;
                OP_WR_SPR_DATA: sprite_addr_reg <= sprite_addr_reg + 1'b1;
                OP_WR_SCROLL:
                begin
                    scroll_reg[write_toggle_reg] <= op.data;
                    write_toggle_reg <= !write_toggle_reg;
                end
                OP_WR_ADDR:
                begin
                    if (!write_toggle_reg)
                    begin
                        addr_high_hold_reg <= op.data;
                    end
                    else
                    begin
                        video_addr_reg         <= {addr_high_hold_reg[5:0], op.data};
                        first_read_pending_reg <= 1'b1;
                    end
                    write_toggle_reg <= !write_toggle_reg;
                end
                OP_WR_DATA:
                begin
                    // Backdrop writes fan out to every mirror; other
                    // backdrop-aligned entries drop the write
                    if (in_palette)
                    begin
                        if (mem_addr[3:0] == 4'h0)
                        begin
                            for (int i = 0; i < PALETTE_BYTES / 4; i++)
                            begin
                                palette_reg[i * 4] <= op.data;
                            end
                        end
                        else if (mem_addr[1:0] != 2'b00)
                        begin
                            palette_reg[mem_addr[4:0]] <= op.data;
                        end
                    end
                    video_addr_reg <= addr_stepped;
                end
                OP_EVENT:       status_flags_reg <= status_flags_reg | op.data;
                OP_RD_BUFFER,
                OP_NOP:         ;
                default:        ;
            endcase
        end
    end

    // Sprite memory: write only through this port
    always_ff @(posedge clk)
    begin
        if (fire && (op.kind == OP_WR_SPR_DATA))
        begin
            sprite_mem[sprite_addr_reg] <= op.data;
        end
    end

    // Pattern memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pattern_mem[pat_waddr] <= pat_wdata;
        end
        if (pat_rd)
        begin
            pat_q_reg <= pattern_mem[mem_addr[PAT_AW-1:0]];
        end
    end

    // Nametable memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nametable_mem[nt_waddr] <= nt_wdata;
        end
        if (nt_rd)
        begin
            nt_q_reg <= nametable_mem[nt_idx];
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench for video_chip_register_port_top: register, mirroring and random access checks.
// Depends on vcrp_pkg and the RTL of the block; predicts every result byte locally.
`timescale 1ns / 1ps

module tb;
    import vcrp_pkg::*;

    localparam int NT_BYTES    = NT_BYTES_DEFAULT;
    localparam int QUIET_LIMIT = 50000;

    // Function code with no defined operation
    localparam logic [1:0] FUNC_IDLE = 2'd3;

    // Start of the nametable region in the video address space
    localparam logic [VADDR_W-1:0] NT_BASE = 14'h2000;

    // Physical page per {mode, window}, two bits each, mode 0 in the low byte
    localparam logic [31:0] PAGE_MAP = 32'hE4_44_50_E4;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       mirroring_we   = 1'b0;
    logic [1:0] mirroring_mode = 2'd0;
    logic       push           = 1'b0;
    logic       full;
    logic [1:0] func           = 2'd0;
    logic [2:0] reg_index      = 3'd0;
    logic [7:0] write_data     = 8'd0;
    logic       empty;
    logic       pop            = 1'b0;
    logic [7:0] read_data;

    // Bytes the block owes, oldest first
    logic [7:0] read_data_due [$];
    logic [7:0] due_byte;
    int         error_count   = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 0;
    int         pop_stall_pct = 0;
    int         quiet_cycles  = 0;

    // Shadow state of the register port
    logic [1:0]         mirror_sel    = 2'd0;
    logic [7:0]         sh_ctrl       = 8'd0;
    logic [7:0]         sh_mask       = 8'd0;
    logic [7:0]         sh_spr_addr   = 8'd0;
    logic [7:0]         sh_scroll [2] = '{8'd0, 8'd0};
    logic               sh_toggle     = 1'b0;
    logic [7:0]         sh_addr_hi    = 8'd0;
    logic [VADDR_W-1:0] sh_vaddr      = '0;
    logic               sh_first_read = 1'b0;
    logic [7:0]         sh_rbuf       = 8'd0;
    logic [7:0]         sh_status     = 8'd0;
    logic [7:0]         spr_shadow [SPRITE_BYTES];
    logic [7:0]         pat_shadow [PATTERN_BYTES];
    logic [7:0]         nt_shadow  [NT_BYTES];
    logic [7:0]         pal_shadow [PALETTE_BYTES];

    video_chip_register_port_top #(
        .NAMETABLE_BYTES(NT_BYTES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .mirroring_we   (mirroring_we),
        .mirroring_mode (mirroring_mode),
        .push           (push),
        .full           (full),
        .func           (func),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .empty          (empty),
        .pop            (pop),
        .read_data      (read_data)
    );

    // Free-running clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Physical nametable entry behind a video address
    function automatic int unsigned nt_slot(input logic [VADDR_W-1:0] a);
        int unsigned sel;
        int unsigned page;
        sel  = 32'({mirror_sel, a[11:10]});
        page = 32'(PAGE_MAP[2 * sel +: 2]);
        return (page * 1024 + 32'(a[9:0])) % NT_BYTES;
    endfunction

    // Step the video address by 1 or 32, wrapping in 14 bits
    function automatic void advance_vaddr();
        if (sh_ctrl[CTRL_STEP32_BIT])
            sh_vaddr = sh_vaddr + 14'(ADDR_STEP_WIDE);
        else
            sh_vaddr = sh_vaddr + 14'd1;
    endfunction

    // Apply one bus access to the shadow state and return the byte it yields
    function automatic logic [7:0] compute_read_data(input logic [1:0] f, input logic [2:0] r,
                                                     input logic [7:0] d);
        logic [7:0] rd;
        int         i;
        rd = 8'h00;
        case (f)
            FUNC_READ:
            begin
                if (r == REG_STATUS)
                begin
                    rd        = sh_status;
                    sh_status = sh_status & ~STATUS_VBLANK;
                    sh_toggle = 1'b0;
                end
                else if (r == REG_DATA)
                begin
                    rd = sh_rbuf;
                    if (sh_first_read)
                        sh_first_read = 1'b0;
                    else
                        advance_vaddr();
                    // Refill; the palette range reads the nametable mirror
                    if (sh_vaddr < NT_BASE)
                        sh_rbuf = pat_shadow[sh_vaddr[12:0]];
                    else
                        sh_rbuf = nt_shadow[nt_slot(sh_vaddr)];
                end
                else
                begin
                    rd = sh_rbuf;
                end
            end
            FUNC_WRITE:
            begin
                case (r)
                    REG_CTRL:     sh_ctrl = d;
                    REG_MASK:     sh_mask = d;
                    REG_SPR_ADDR: sh_spr_addr = d;
                    REG_SPR_DATA:
                    begin
                        spr_shadow[sh_spr_addr] = d;
                        sh_spr_addr = sh_spr_addr + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        sh_scroll[sh_toggle] = d;
                        sh_toggle = ~sh_toggle;
                    end
                    REG_ADDR:
                    begin
                        if (!sh_toggle)
                        begin
                            sh_addr_hi = d;
                        end
                        else
                        begin
                            sh_vaddr      = {sh_addr_hi[5:0], d};
                            sh_first_read = 1'b1;
                        end
                        sh_toggle = ~sh_toggle;
                    end
                    REG_DATA:
                    begin
                        if (sh_vaddr >= PALETTE_BASE)
                        begin
                            // Backdrop writes hit all eight mirrors; other
                            // entries with low bits zero are dropped
                            if (sh_vaddr[3:0] == 4'd0)
                            begin
                                for (i = 0; i < PALETTE_BYTES; i += 4)
                                    pal_shadow[i] = d;
                            end
                            else if (sh_vaddr[1:0] != 2'd0)
                            begin
                                pal_shadow[sh_vaddr[4:0]] = d;
                            end
                        end
                        else if (sh_vaddr < NT_BASE)
                        begin
                            pat_shadow[sh_vaddr[12:0]] = d;
                        end
                        else
                        begin
                            nt_shadow[nt_slot(sh_vaddr)] = d;
                        end
                        advance_vaddr();
                    end
                    default: ;
                endcase
            end
            FUNC_EVENT: sh_status = sh_status | d;
            default: ;
        endcase
        return rd;
    endfunction

    // Check each result transfer against the oldest due byte; drive pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (read_data_due.size() == 0)
            begin
                $error("read_data: unexpected result, expected none, actual %02h", read_data);
                error_count++;
            end
            else
            begin
                due_byte = read_data_due.pop_front();
                if (read_data !== due_byte)
                begin
                    $error("read_data mismatch: expected %02h, actual %02h", due_byte, read_data);
                    error_count++;
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one access, with random idle cycles ahead of it
    task automatic send_access(input logic [1:0] f, input logic [2:0] r, input logic [7:0] d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        func       <= f;
        reg_index  <= r;
        write_data <= d;
        @(posedge clk);
        while (full)
            @(posedge clk);
        read_data_due.push_back(compute_read_data(f, r, d));
        items_sent++;
    endtask

    // Clear the toggle, then load the video address in two writes
    task automatic aim_vaddr(input logic [7:0] hi, input logic [7:0] lo);
        send_access(FUNC_READ, REG_STATUS, 8'($urandom));
        send_access(FUNC_WRITE, REG_ADDR, hi);
        send_access(FUNC_WRITE, REG_ADDR, lo);
    endtask

    // Hold push low until every due byte has come back
    task automatic drain_results();
        push <= 1'b0;
        while (read_data_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the mirroring register; only called with nothing in flight
    task automatic set_mirroring(input logic [1:0] mode);
        mirroring_we   <= 1'b1;
        mirroring_mode <= mode;
        @(posedge clk);
        mirroring_we   <= 1'b0;
        mirror_sel = mode;
    endtask

    // Every register, status flags, palette corner cases, step and wrap
    task automatic run_register_ops();
        send_access(FUNC_READ,  REG_CTRL,     8'h00);
        send_access(FUNC_EVENT, REG_CTRL,     8'hFF);
        send_access(FUNC_READ,  REG_STATUS,   8'hFF);
        send_access(FUNC_READ,  REG_STATUS,   8'h00);
        send_access(FUNC_IDLE,  REG_DATA,     8'hFF);
        send_access(FUNC_WRITE, REG_STATUS,   8'hAA);
        send_access(FUNC_WRITE, REG_CTRL,     8'h00);
        send_access(FUNC_WRITE, REG_MASK,     8'hFF);
        send_access(FUNC_WRITE, REG_SPR_ADDR, 8'hFF);
        send_access(FUNC_WRITE, REG_SPR_DATA, 8'h00);
        send_access(FUNC_WRITE, REG_SCROLL,   8'h12);
        send_access(FUNC_WRITE, REG_SCROLL,   8'hED);
        // High byte with the top two bits set lands on the backdrop entry
        send_access(FUNC_WRITE, REG_ADDR,     8'hFF);
        send_access(FUNC_WRITE, REG_ADDR,     8'h00);
        send_access(FUNC_WRITE, REG_DATA,     8'h2A);
        // Palette entry with low two bits zero: write dropped
        send_access(FUNC_WRITE, REG_ADDR,     8'h3F);
        send_access(FUNC_WRITE, REG_ADDR,     8'h04);
        send_access(FUNC_WRITE, REG_DATA,     8'h55);
        send_access(FUNC_READ,  REG_DATA,     8'h00);
        // Step by 32 across the top of the address space
        send_access(FUNC_WRITE, REG_CTRL,     8'h04);
        send_access(FUNC_WRITE, REG_ADDR,     8'h3F);
        send_access(FUNC_WRITE, REG_ADDR,     8'hFF);
        send_access(FUNC_WRITE, REG_DATA,     8'h99);
        send_access(FUNC_READ,  REG_DATA,     8'h00);
        send_access(FUNC_READ,  REG_DATA,     8'h00);
    endtask

    // Write each nametable window, read it back, under every mapping
    task automatic run_mirroring();
        logic [1:0] modes [4];
        logic [7:0] hi [4];
        logic [7:0] lo [4];
        int         m;
        int         w;
        modes = '{MIRROR_NONE, MIRROR_FOUR, MIRROR_HORIZONTAL, MIRROR_VERTICAL};
        for (m = 0; m < 4; m++)
        begin
            drain_results();
            set_mirroring(modes[m]);
            send_access(FUNC_WRITE, REG_CTRL, 8'h00);
            for (w = 0; w < 4; w++)
            begin
                hi[w] = 8'h20 | 8'(w << 2) | 8'($urandom_range(0, 3));
                lo[w] = 8'($urandom);
                aim_vaddr(hi[w], lo[w]);
                send_access(FUNC_WRITE, REG_DATA, 8'($urandom));
            end
            for (w = 0; w < 4; w++)
            begin
                aim_vaddr(hi[w], lo[w]);
                send_access(FUNC_READ, REG_DATA, 8'($urandom));
                send_access(FUNC_READ, REG_DATA, 8'($urandom));
            end
            // Palette range reads fill from the window 3 mirror
            aim_vaddr(8'h3F, 8'($urandom));
            send_access(FUNC_READ, REG_DATA, 8'($urandom));
            send_access(FUNC_READ, REG_DATA, 8'($urandom));
        end
    endtask

    // Write a burst of bytes from one start address, then read it back
    task automatic data_burst();
        logic [7:0]  hi;
        logic [7:0]  lo;
        int unsigned n;
        case ($urandom_range(0, 3))
            0:       hi = 8'($urandom_range(8'h00, 8'h1F));
            1:       hi = 8'($urandom_range(8'h20, 8'h3E));
            2:       hi = 8'h3F;
            default: hi = 8'($urandom_range(8'h00, 8'h3F));
        endcase
        hi[7:6] = 2'($urandom_range(0, 3));
        lo      = 8'($urandom);
        n       = $urandom_range(1, 8);
        if ($urandom_range(0, 1))
            send_access(FUNC_WRITE, REG_CTRL, 8'($urandom));
        aim_vaddr(hi, lo);
        repeat (n)
            send_access(FUNC_WRITE, REG_DATA, 8'($urandom));
        aim_vaddr(hi, lo);
        repeat (n + 1)
            send_access(FUNC_READ, REG_DATA, 8'($urandom));
    endtask

    // Mostly write/read-back bursts, mixed with noise and broken sequences
    task automatic run_random_traffic(input int idle_pct, input int stall_pct, input int count);
        int          stop_at;
        int unsigned pick;
        logic [1:0]  f;
        drain_results();
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        set_mirroring(2'($urandom_range(0, 3)));
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                data_burst();
            end
            else if (pick < 85)
            begin
                f = ($urandom_range(0, 99) < 3) ? FUNC_IDLE : 2'($urandom_range(0, 2));
                send_access(f, 3'($urandom), 8'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    // Half an address load flips the toggle
                    0: send_access(FUNC_WRITE, REG_ADDR, 8'($urandom));
                    1:
                    begin
                        send_access(FUNC_EVENT, 3'($urandom), 8'($urandom));
                        send_access(FUNC_READ, REG_STATUS, 8'($urandom));
                    end
                    default:
                    begin
                        repeat ($urandom_range(1, 3))
                            send_access(FUNC_WRITE, REG_SCROLL, 8'($urandom));
                    end
                endcase
            end
        end
    endtask

    // Reset, wait out the memory sweep, run the tests, report
    initial
    begin
        for (int i = 0; i < PATTERN_BYTES; i++)
            pat_shadow[i] = 8'd0;
        for (int i = 0; i < NT_BYTES; i++)
            nt_shadow[i] = 8'd0;
        for (int i = 0; i < PALETTE_BYTES; i++)
            pal_shadow[i] = 8'd0;
        for (int i = 0; i < SPRITE_BYTES; i++)
            spr_shadow[i] = 8'd0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        set_mirroring(MIRROR_NONE);
        run_register_ops();
        run_mirroring();
        run_random_traffic(0, 0, 440);
        run_random_traffic(78, 0, 440);
        run_random_traffic(0, 78, 440);
        run_random_traffic(18, 18, 440);
        drain_results();
        repeat (8)
            @(posedge clk);
        if (error_count == 0 && read_data_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
